// ===== hw/rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: widths, result kinds, defaults.
package qrs_pkg;

  localparam int QRS_FRAC_BITS = 16;
  localparam int QRS_CW        = 32;   // coefficient and root width
  localparam int QRS_DISC_W    = 68;   // discriminant, two bits per sqrt step
  localparam int QRS_SQ_STEPS  = QRS_DISC_W / 2;
  localparam int QRS_ROOT_W    = QRS_SQ_STEPS;
  localparam int QRS_SQREM_W   = QRS_ROOT_W + 4;
  localparam int QRS_NUM_W     = 36;   // signed numerator -b +/- s
  localparam int QRS_MAG_W     = QRS_NUM_W - 1;
  localparam int QRS_DEN_W     = 33;   // magnitude of 2a or b

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIN  = 2'd1,
    KIND_QUAD = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [QRS_CW-1:0]  a;
    logic [QRS_CW-1:0]  b;
    logic [QRS_CW-1:0]  c;
  } side_t;

endpackage

// ===== hw/rtl/quadratic_root_solver_top.sv =====
// Quadratic root solver: fixed-point real roots of a x^2 + b x + c = 0.
// Pipeline: coefficient capture, product and discriminant registers, then the
//   34-step square-root pipeline, the divider setup register, the
//   one-bit-per-stage restoring divider, and the output register.
// Throughput: one beat per cycle unless stalled; every stage advances on one enable.
// Reset: rst clears only the valid bits of all stages and the output register.
module quadratic_root_solver_top
  import qrs_pkg::*;
#(
  parameter int FRAC_BITS = QRS_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [QRS_CW-1:0] coef_a,
  input  logic signed [QRS_CW-1:0] coef_b,
  input  logic signed [QRS_CW-1:0] coef_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               root_count,
  output logic signed [QRS_CW-1:0] root_low,
  output logic signed [QRS_CW-1:0] root_high,
  output logic                     saturated
);

  // Quotient width: 35-bit numerator magnitude scaled by 2^F.
  localparam int NW = QRS_MAG_W + FRAC_BITS;

  // Whole pipeline moves when the output register is free or being taken.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: capture coefficients ----------------
  logic  s1_v;
  side_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
    if (adv) begin
      s1.kind <= KIND_NONE;
      s1.a    <= coef_a;
      s1.b    <= coef_b;
      s1.c    <= coef_c;
    end
  end

  // ---------------- stage 2: b*b and a*c magnitudes ----------------
  logic [QRS_CW-1:0]   a_mag, b_mag, c_mag;
  assign a_mag = s1.a[QRS_CW-1] ? (~s1.a + 1'b1) : s1.a;
  assign b_mag = s1.b[QRS_CW-1] ? (~s1.b + 1'b1) : s1.b;
  assign c_mag = s1.c[QRS_CW-1] ? (~s1.c + 1'b1) : s1.c;

  logic                  s2_v;
  side_t                 s2;
  logic [2*QRS_CW-1:0]   s2_bb, s2_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
    if (adv) begin
      s2    <= s1;
      s2_bb <= b_mag * b_mag;
      s2_p  <= a_mag * c_mag;
    end
  end

  // ---------------- stage 3: discriminant and case decision ----------------
  logic [QRS_DISC_W-1:0] bb_x, p4_x, disc_next;
  logic                  same_sign, disc_neg;
  kind_t                 kind_next;
  always_comb begin
    bb_x      = QRS_DISC_W'(s2_bb);
    p4_x      = QRS_DISC_W'(s2_p) << 2;
    same_sign = (s2.a[QRS_CW-1] == s2.c[QRS_CW-1]) && (s2_p != '0);
    disc_neg  = same_sign && (p4_x > bb_x);
    disc_next = same_sign ? (bb_x - p4_x) : (bb_x + p4_x);
    if (s2.a == '0) begin
      kind_next = (s2.b == '0) ? KIND_NONE : KIND_LIN;
    end else begin
      kind_next = disc_neg ? KIND_NONE : KIND_QUAD;
    end
  end

  logic                  s3_v;
  side_t                 s3;
  logic [QRS_DISC_W-1:0] s3_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
    if (adv) begin
      s3   <= '{kind: kind_next, a: s2.a, b: s2.b, c: s2.c};
      s3_d <= disc_next;
    end
  end

  // ---------------- square root: one result bit per stage ----------------
  logic                   sq_v    [QRS_SQ_STEPS+1];
  side_t                  sq_side [QRS_SQ_STEPS+1];
  logic [QRS_DISC_W-1:0]  sq_d    [QRS_SQ_STEPS+1];
  logic [QRS_SQREM_W-1:0] sq_rem  [QRS_SQ_STEPS+1];
  logic [QRS_ROOT_W-1:0]  sq_root [QRS_SQ_STEPS+1];

  assign sq_v[0]    = s3_v;
  assign sq_side[0] = s3;
  assign sq_d[0]    = s3_d;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < QRS_SQ_STEPS; k++) begin : g_sqrt
    logic [QRS_SQREM_W-1:0] rem_sh, trial;
    logic                   take;
    assign rem_sh = {sq_rem[k][QRS_SQREM_W-3:0], sq_d[k][QRS_DISC_W-1 -: 2]};
    assign trial  = (QRS_SQREM_W'(sq_root[k]) << 2) | QRS_SQREM_W'(1);
    assign take   = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (adv) begin
        sq_side[k+1] <= sq_side[k];
        sq_d[k+1]    <= sq_d[k] << 2;
        sq_rem[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        sq_root[k+1] <= {sq_root[k][QRS_ROOT_W-2:0], take};
      end
    end
  end

  // ---------------- divider setup: numerators, divisor, signs ----------------
  logic signed [QRS_NUM_W-1:0] bx, sx, cx, num0, num1;
  logic signed [QRS_DEN_W:0]   den_s;
  logic [QRS_NUM_W-1:0]        mag0, mag1;
  logic [QRS_DEN_W:0]          den_m;
  side_t                       sq_out;
  always_comb begin
    sq_out = sq_side[QRS_SQ_STEPS];
    bx     = QRS_NUM_W'(signed'(sq_out.b));
    cx     = QRS_NUM_W'(signed'(sq_out.c));
    sx     = signed'(QRS_NUM_W'(sq_root[QRS_SQ_STEPS]));
    if (sq_out.kind == KIND_LIN) begin
      num0  = -cx;
      den_s = (QRS_DEN_W+1)'(signed'(sq_out.b));
    end else begin
      num0  = sx - bx;
      den_s = (QRS_DEN_W+1)'(signed'(sq_out.a)) <<< 1;
    end
    num1  = -bx - sx;
    mag0  = num0[QRS_NUM_W-1] ? -num0 : num0;
    mag1  = num1[QRS_NUM_W-1] ? -num1 : num1;
    den_m = den_s[QRS_DEN_W] ? -den_s : den_s;
  end

  logic                  dv_v    [NW+1];
  kind_t                 dv_kind [NW+1];
  logic [1:0]            dv_neg  [NW+1];
  logic [QRS_DEN_W-1:0]  dv_den  [NW+1];
  logic [NW-1:0]         dv_nq0  [NW+1];
  logic [NW-1:0]         dv_nq1  [NW+1];
  logic [QRS_DEN_W-1:0]  dv_rem0 [NW+1];
  logic [QRS_DEN_W-1:0]  dv_rem1 [NW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[QRS_SQ_STEPS];
    end
    if (adv) begin
      dv_kind[0] <= sq_out.kind;
      dv_neg[0]  <= {num1[QRS_NUM_W-1] ^ den_s[QRS_DEN_W],
                     num0[QRS_NUM_W-1] ^ den_s[QRS_DEN_W]};
      dv_den[0]  <= den_m[QRS_DEN_W-1:0];
      dv_nq0[0]  <= NW'(mag0[QRS_MAG_W-1:0]) << FRAC_BITS;
      dv_nq1[0]  <= NW'(mag1[QRS_MAG_W-1:0]) << FRAC_BITS;
      dv_rem0[0] <= '0;
      dv_rem1[0] <= '0;
    end
  end

  // ---------------- restoring divider: one quotient bit per stage ----------------
  // Numerator bits shift out the top while quotient bits shift in below.
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [QRS_DEN_W:0] sh0, sh1, dext;
    logic               t0, t1;
    assign dext = {1'b0, dv_den[j]};
    assign sh0  = {dv_rem0[j], dv_nq0[j][NW-1]};
    assign sh1  = {dv_rem1[j], dv_nq1[j][NW-1]};
    assign t0   = (sh0 >= dext);
    assign t1   = (sh1 >= dext);
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (adv) begin
        dv_kind[j+1] <= dv_kind[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_den[j+1]  <= dv_den[j];
        dv_rem0[j+1] <= QRS_DEN_W'(t0 ? (sh0 - dext) : sh0);
        dv_rem1[j+1] <= QRS_DEN_W'(t1 ? (sh1 - dext) : sh1);
        dv_nq0[j+1]  <= {dv_nq0[j][NW-2:0], t0};
        dv_nq1[j+1]  <= {dv_nq1[j][NW-2:0], t1};
      end
    end
  end

  // ---------------- clamp, order, and output register ----------------
  localparam logic [NW-1:0] POS_LIM = NW'(32'h7FFF_FFFF);
  localparam logic [NW-1:0] NEG_LIM = NW'(33'h1_0000_0000) >> 1;

  logic [QRS_CW-1:0] r0, r1;
  logic              sat0, sat1;
  logic [1:0]        count_next;
  logic [QRS_CW-1:0] low_next, high_next;
  logic              sat_next;
  logic [NW-1:0]     q0, q1;
  logic [NW-1:0]     nq0_neg, nq1_neg;
  always_comb begin
    q0      = dv_nq0[NW];
    q1      = dv_nq1[NW];
    nq0_neg = -q0;
    nq1_neg = -q1;
    if (dv_neg[NW][0]) begin
      sat0 = (q0 > NEG_LIM);
      r0   = sat0 ? 32'h8000_0000 : nq0_neg[QRS_CW-1:0];
    end else begin
      sat0 = (q0 > POS_LIM);
      r0   = sat0 ? 32'h7FFF_FFFF : q0[QRS_CW-1:0];
    end
    if (dv_neg[NW][1]) begin
      sat1 = (q1 > NEG_LIM);
      r1   = sat1 ? 32'h8000_0000 : nq1_neg[QRS_CW-1:0];
    end else begin
      sat1 = (q1 > POS_LIM);
      r1   = sat1 ? 32'h7FFF_FFFF : q1[QRS_CW-1:0];
    end
    count_next = 2'd0;
    low_next   = '0;
    high_next  = '0;
    sat_next   = 1'b0;
    case (dv_kind[NW])
      KIND_LIN: begin
        count_next = 2'd1;
        low_next   = r0;
        sat_next   = sat0;
      end
      KIND_QUAD: begin
        count_next = 2'd2;
        sat_next   = sat0 | sat1;
        // Put the smaller root first.
        if ($signed(r1) < $signed(r0)) begin
          low_next  = r1;
          high_next = r0;
        end else begin
          low_next  = r0;
          high_next = r1;
        end
      end
      default: begin
        count_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[NW];
    end
    if (adv) begin
      root_count <= count_next;
      root_low   <= low_next;
      root_high  <= high_next;
      saturated  <= sat_next;
    end
  end

  // ---------------- assertions ----------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (root_count != 2'd3))
    else $error("root_count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && root_count == 2'd0) |->
      (root_low == '0 && root_high == '0 && !saturated))
    else $error("no-root beat carries nonzero fields");

  a_high_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && root_count != 2'd2) |-> (root_high == '0))
    else $error("root_high set without two roots");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && root_count == 2'd2) |-> (root_low <= root_high))
    else $error("roots out of order");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output blocked");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the fixed-point quadratic root solver.
`timescale 1ns / 1ps

module tb_top
  import qrs_pkg::*;
();

  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_TAIL   = 200;     // last beats sent with no idling
  localparam int DRAIN_CYCLES = 200;     // well above the pipeline latency
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_LEN     = 400;     // receiver long hold-off

  typedef struct {
    logic [1:0]               count;
    logic signed [QRS_CW-1:0] lo;
    logic signed [QRS_CW-1:0] hi;
    logic                     sat;
  } roots_t;

  typedef struct {
    logic signed [QRS_CW-1:0] a;
    logic signed [QRS_CW-1:0] b;
    logic signed [QRS_CW-1:0] c;
    bit                       typed;
    roots_t                   want;
  } coef_row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [QRS_CW-1:0] coef_a;
  logic signed [QRS_CW-1:0] coef_b;
  logic signed [QRS_CW-1:0] coef_c;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               root_count;
  logic signed [QRS_CW-1:0] root_low;
  logic signed [QRS_CW-1:0] root_high;
  logic                     saturated;

  coef_row_t stim_q[$];
  roots_t    pending_roots[$];
  int        errors;
  int        cycle_cnt;
  bit        quiet;
  bit        hold_req;
  bit        sending_done;

  quadratic_root_solver_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .coef_c     (coef_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .root_count (root_count),
    .root_low   (root_low),
    .root_high  (root_high),
    .saturated  (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of the square root of a nonnegative discriminant below 2^68.
  function automatic logic [127:0] floor_sqrt(input logic [127:0] d);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int k = QRS_SQ_STEPS - 1; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= d) r = t;
    end
    return r;
  endfunction

  // (num * 2^F) / den truncated toward zero, then clamped to 32 bits.
  function automatic logic [QRS_CW-1:0] div_clamp(input longint num, input longint den,
                                                  inout logic sat);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    bit              neg;
    n   = (num < 0 ? -num : num);
    n   = n << QRS_FRAC_BITS;
    d   = (den < 0 ? -den : den);
    q   = n / d;
    neg = (num < 0) != (den < 0);
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return 32'(q);
  endfunction

  function automatic roots_t solve_roots(input logic signed [QRS_CW-1:0] a,
                                         input logic signed [QRS_CW-1:0] b,
                                         input logic signed [QRS_CW-1:0] c);
    roots_t               r;
    longint               sa;
    longint               sb;
    longint               sc;
    logic signed [127:0]  wa;
    logic signed [127:0]  wb;
    logic signed [127:0]  wc;
    logic signed [127:0]  disc;
    longint               s;
    logic signed [QRS_CW-1:0] r0;
    logic signed [QRS_CW-1:0] r1;
    logic signed [QRS_CW-1:0] t;
    r  = '{count: 2'd0, lo: '0, hi: '0, sat: 1'b0};
    sa = a;
    sb = b;
    sc = c;
    if (sa == 0) begin
      if (sb == 0) return r;
      r.count = 2'd1;
      r.lo    = div_clamp(-sc, sb, r.sat);
      return r;
    end
    wa   = sa;
    wb   = sb;
    wc   = sc;
    disc = wb * wb - 4 * wa * wc;
    if (disc < 0) return r;
    s  = longint'(floor_sqrt(disc));
    r0 = div_clamp(-sb + s, 2 * sa, r.sat);
    r1 = div_clamp(-sb - s, 2 * sa, r.sat);
    if (r1 < r0) begin
      t  = r0;
      r0 = r1;
      r1 = t;
    end
    r.count = 2'd2;
    r.lo    = r0;
    r.hi    = r1;
    return r;
  endfunction

  // Random coefficient: mostly small magnitudes so roots stay in range, some
  // full-width values, a few extremes and zeros.
  function automatic logic signed [QRS_CW-1:0] pick_coef();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        return $signed(32'($urandom_range(0, 32'h0008_0000))) *
               ($urandom_range(0, 1) ? 1 : -1);
      end
      4, 5, 6:    return $urandom;
      7:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      8:          return $urandom_range(0, 1) ? 32'sd0 : 32'sd1;
      default:    return $signed(32'($urandom_range(0, 255))) - 32'sd128;
    endcase
  endfunction

  task automatic add_row(input logic signed [QRS_CW-1:0] a,
                         input logic signed [QRS_CW-1:0] b,
                         input logic signed [QRS_CW-1:0] c,
                         input bit typed, input logic [1:0] cnt,
                         input logic signed [QRS_CW-1:0] lo,
                         input logic signed [QRS_CW-1:0] hi,
                         input logic sat);
    coef_row_t row;
    row.a     = a;
    row.b     = b;
    row.c     = c;
    row.typed = typed;
    row.want  = '{count: cnt, lo: lo, hi: hi, sat: sat};
    stim_q.push_back(row);
  endtask

  // Build the directed table, then the random stream behind it.
  initial begin
    coef_row_t row;
    int        kind;
    // a and b zero: no roots, even with c zero
    add_row(32'sd0, 32'sd0, 32'sd0, 1, 2'd0, 0, 0, 0);
    add_row(32'sd0, 32'sd0, 32'h7FFF_FFFF, 1, 2'd0, 0, 0, 0);
    // linear: x = 2.0
    add_row(32'sd0, 32'h0001_0000, -32'sh0002_0000, 1, 2'd1, 32'h0002_0000, 0, 0);
    // linear with clamping, both directions
    add_row(32'sd0, 32'sd1, 32'h8000_0000, 1, 2'd1, 32'h7FFF_FFFF, 0, 1);
    add_row(32'sd0, 32'sd1, 32'h7FFF_FFFF, 1, 2'd1, 32'h8000_0000, 0, 1);
    // negative discriminant: x^2 + 1
    add_row(32'h0001_0000, 32'sd0, 32'h0001_0000, 1, 2'd0, 0, 0, 0);
    // x^2 - 4: roots -2.0, 2.0
    add_row(32'h0001_0000, 32'sd0, -32'sh0004_0000, 1, 2'd2,
            -32'sh0002_0000, 32'h0002_0000, 0);
    // zero discriminant: x^2 + 2x + 1, double root at -1.0
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1, 2'd2,
            -32'sh0001_0000, -32'sh0001_0000, 0);
    // extremes and mixed signs, checked by the predictor
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(32'sd1, 32'h8000_0000, 32'sd0, 0, 0, 0, 0, 0);
    add_row(32'sd1, 32'sd0, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(-32'sd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_row(32'sd0, -32'sd1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      row.typed = 0;
      row.want  = '{count: 2'd0, lo: '0, hi: '0, sat: 1'b0};
      row.a     = pick_coef();
      row.b     = pick_coef();
      row.c     = pick_coef();
      kind      = $urandom_range(0, 9);
      // bias toward real roots: opposite signs of a and c
      if (kind < 4 && row.a != 0 && row.c != 0 && (row.a < 0) == (row.c < 0))
        row.c = -row.c;
      else if (kind == 4)
        row.a = 32'sd0;
      stim_q.push_back(row);
    end
  end

  // Sender: present beats in order, random idle bursts until the quiet tail.
  initial begin
    coef_row_t row;
    int        total;
    in_valid     = 1'b0;
    coef_a       = '0;
    coef_b       = '0;
    coef_c       = '0;
    rst          = 1'b1;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    sending_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #0;
    total = stim_q.size();
    for (int i = 0; i < total; i++) begin
      row = stim_q.pop_front();
      if (i >= total - QUIET_TAIL) quiet = 1'b1;
      // halfway through, ask the receiver for its long hold-off
      if (i == total / 2) hold_req = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      in_valid <= 1'b1;
      coef_a   <= row.a;
      coef_b   <= row.b;
      coef_c   <= row.c;
      // wait for the beat to be taken
      do @(posedge clk); while (in_stall);
      pending_roots.push_back(row.typed ? row.want : solve_roots(row.a, row.b, row.c));
    end
    in_valid     <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: check each result beat, stall in bursts, and once hold off long
  // enough that the pipeline fills and stalls the input.
  initial begin
    int     stall_left;
    int     hold_left;
    bit     hold_done;
    roots_t want;
    out_stall  = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_roots.size() == 0) begin
          $display("%0t: unexpected result beat count=%0d low=%h high=%h sat=%b",
                   $time, root_count, root_low, root_high, saturated);
          errors++;
        end else begin
          want = pending_roots.pop_front();
          if (root_count !== want.count) begin
            $display("%0t: root_count expected %0d actual %0d", $time, want.count,
                     root_count);
            errors++;
          end
          if (root_low !== want.lo) begin
            $display("%0t: root_low expected %h actual %h", $time, want.lo, root_low);
            errors++;
          end
          if (root_high !== want.hi) begin
            $display("%0t: root_high expected %h actual %h", $time, want.hi, root_high);
            errors++;
          end
          if (saturated !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up at a generous cycle limit.
  initial begin
    errors    = 0;
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // End of run: drain expectations, then let any stray beat show up.
  initial begin
    wait (sending_done);
    wait (pending_roots.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
